/* hdl/region_label_automaton_step_core_defines.svh */
// assertion macros for the region label automaton step core
// used by the checker module only
`ifndef REGION_LABEL_AUTOMATON_STEP_CORE_DEFINES_SVH
`define REGION_LABEL_AUTOMATON_STEP_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define RLA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/rla_pkg.sv */
// shared types and constants for the region label automaton step core
// no dependencies
`default_nettype none
package rla_pkg;
  localparam int NUM_REGIONS_DEF = 16;
  localparam int NUM_STATES_DEF  = 16;
  localparam int MAX_LABELS_DEF  = 8;
  localparam int ACTION_BITS_DEF = 32;

  localparam logic [1:0] KIND_REGION = 2'd0;
  localparam logic [1:0] KIND_LABEL  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic CFG_REGION_COUNT = 1'b0;
  localparam logic CFG_STATE_COUNT  = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         region_index;
    logic [4:0]         interest_bit;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] x_high;
    logic signed [31:0] y_high;
    logic [3:0]         from_state;
    logic [3:0]         to_state;
    logic [2:0]         label_slot;
    logic [31:0]        label_word;
    logic               flag;
  } rla_in_t;

  typedef struct packed {
    logic [3:0]  next_state;
    logic [31:0] action_word;
    logic        matched;
  } rla_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG_RD,
    ST_REG_CHK,
    ST_LBL_RD,
    ST_LBL_CHK,
    ST_DONE
  } rla_state_t;

  // scan control record (read valid, last entry); no module in the project uses it
  typedef struct packed {
    logic rd_valid;
    logic last_entry;
  } rla_scan_t;
endpackage
`default_nettype wire

/* hdl/rla_ram.sv */
// generic ram with one write port and one registered read port
// no dependencies
`default_nettype none
module rla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/rla_valid_mem.sv */
// label valid store: ram of valid bits plus a clearing sweep after reset
// depends on rla_ram
`default_nettype none
module rla_valid_mem #(
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic                     wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic                          rdata,
  output logic                          clr_busy
);
  localparam int AW = $clog2(DEPTH);
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          clr_busy_r, clr_busy_nxt;
  logic          ram_we, ram_wd;
  logic [AW-1:0] ram_wa;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  assign ram_we   = clr_busy_r | we;
  assign ram_wa   = clr_busy_r ? clr_addr_r : waddr;
  assign ram_wd   = clr_busy_r ? 1'b0 : wdata;
  assign clr_busy = clr_busy_r;

  rla_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(raddr), .rdata(rdata)
  );
endmodule
`default_nettype wire

/* hdl/region_label_automaton_step_core.sv */
// top level of the region label automaton step core
// depends on rla_pkg, rla_ram, rla_valid_mem
//
// channel  direction  handshake
// in_      in         start high and busy low accepts a transaction
// out_     out        out_valid strobes one cycle, no back-pressure
// cfg_     in         cfg_we writes cfg_data to register cfg_index
//
// a load transaction writes its entry in ST_REG_RD and returns to idle; a query walks up to
// region_count regions and then, if its flag is set, up to state_count*MAX_LABELS label
// entries of its from_state, one entry at a time through the one read port of each memory;
// the region walk stops at the first containing region, the label walk at the first match.
// after reset busy stays high while all NUM_STATES*NUM_STATES*MAX_LABELS entries
// of the label valid memory are swept clear; config writes still work.
// results cannot be stalled, the strobe lasts one cycle.
`default_nettype none
module region_label_automaton_step_core
  import rla_pkg::*;
#(
  parameter int NUM_REGIONS = NUM_REGIONS_DEF,
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int MAX_LABELS  = MAX_LABELS_DEF,
  parameter int ACTION_BITS = ACTION_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire rla_in_t    in_item,
  output logic            out_valid,
  output rla_out_t        out_item,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [4:0] cfg_data
);
  localparam int RW  = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int SW  = $clog2(NUM_STATES);
  localparam int LW  = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int LD  = NUM_STATES * NUM_STATES * MAX_LABELS;
  localparam int LAW = $clog2(LD);
  localparam int RGW = 32 * 4 + 5;
  localparam logic [31:0] AMASK = (ACTION_BITS >= 32) ? 32'hFFFF_FFFF
                                 : 32'((64'd1 << ACTION_BITS) - 64'd1);

  rla_state_t state_r, state_nxt;
  rla_in_t    item_r;
  logic [4:0] region_count_r, state_count_r;
  logic [31:0] acc_r, acc_nxt;
  logic [5:0]  ridx_r, ridx_nxt;         // region scan index
  logic [6:0]  didx_r, didx_nxt;         // destination scan index
  logic [5:0]  sidx_r, sidx_nxt;         // slot scan index
  logic        clr_busy;
  logic        accept;

  // saturated counts
  logic [6:0] rcnt, scnt;
  assign rcnt = (7'(region_count_r) > 7'(NUM_REGIONS)) ? 7'(NUM_REGIONS)
              : 7'(region_count_r);
  assign scnt = (7'(state_count_r) > 7'(NUM_STATES)) ? 7'(NUM_STATES)
              : 7'(state_count_r);

  assign accept = start && !busy;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= 5'd0;
      state_count_r  <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_COUNT: region_count_r <= cfg_data;
        CFG_STATE_COUNT:  state_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  // region memory: bounds and label bit packed in one word
  logic          reg_we;
  logic [RW-1:0] reg_wa, reg_ra;
  logic [RGW-1:0] reg_wd, reg_rd;
  logic signed [31:0] rx_lo, rx_hi, ry_lo, ry_hi;
  logic [4:0]    rbit;
  assign reg_we = (state_r == ST_REG_RD) && (item_r.kind == KIND_REGION)
                  && (32'(item_r.region_index) < 32'(NUM_REGIONS));
  assign reg_wa = RW'(item_r.region_index);
  assign reg_wd = {item_r.coord_x, item_r.x_high, item_r.coord_y,
                   item_r.y_high, item_r.interest_bit};
  assign reg_ra = RW'(ridx_r);
  assign {rx_lo, rx_hi, ry_lo, ry_hi, rbit} = reg_rd;

  rla_ram #(.WIDTH(RGW), .DEPTH(NUM_REGIONS)) u_region_ram (
    .clk(clk), .we(reg_we), .waddr(reg_wa), .wdata(reg_wd),
    .raddr(reg_ra), .rdata(reg_rd)
  );

  // label word and valid memories share one address scheme
  logic           lbl_we, lbl_ok;
  logic [LAW-1:0] lbl_wa, lbl_ra;
  logic [31:0]    lbl_rd;
  logic           vld_rd;
  assign lbl_ok = (32'(item_r.from_state) < 32'(NUM_STATES))
               && (32'(item_r.to_state) < 32'(NUM_STATES))
               && (32'(item_r.label_slot) < 32'(MAX_LABELS));
  assign lbl_we = (state_r == ST_REG_RD) && (item_r.kind == KIND_LABEL) && lbl_ok;
  assign lbl_wa = LAW'((32'(item_r.from_state) * NUM_STATES
                 + 32'(item_r.to_state)) * MAX_LABELS + 32'(item_r.label_slot));
  assign lbl_ra = LAW'((32'(item_r.from_state) * NUM_STATES + 32'(didx_r))
                 * MAX_LABELS + 32'(sidx_r));

  rla_ram #(.WIDTH(32), .DEPTH(LD)) u_label_ram (
    .clk(clk), .we(lbl_we), .waddr(lbl_wa), .wdata(item_r.label_word),
    .raddr(lbl_ra), .rdata(lbl_rd)
  );
  rla_valid_mem #(.DEPTH(LD)) u_valid (
    .clk(clk), .rst_n(rst_n), .we(lbl_we), .waddr(lbl_wa),
    .wdata(item_r.flag), .raddr(lbl_ra), .rdata(vld_rd), .clr_busy(clr_busy)
  );

  // containment test on registered region word
  logic inside_hit;
  assign inside_hit = (item_r.coord_x > rx_lo) && (item_r.coord_x < rx_hi)
                   && (item_r.coord_y > ry_lo) && (item_r.coord_y < ry_hi);

  logic hit_r, hit_nxt;
  logic [3:0] next_r, next_nxt;
  logic last_slot, last_dest;
  assign last_slot = (sidx_r == 6'(MAX_LABELS - 1));
  assign last_dest = ((didx_r + 7'd1) >= scnt);

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    ridx_nxt  = ridx_r;
    didx_nxt  = didx_r;
    sidx_nxt  = sidx_r;
    hit_nxt   = hit_r;
    next_nxt  = next_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_REG_RD;
          ridx_nxt  = '0;
        end
      end
      ST_REG_RD: begin
        // load writes happen this cycle; queries start the region walk
        if (item_r.kind != KIND_QUERY) begin
          state_nxt = ST_IDLE;
        end else if (7'(ridx_r) < rcnt) begin
          state_nxt = ST_REG_CHK;
        end else if (item_r.flag) begin
          state_nxt = ST_LBL_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
        didx_nxt = '0;
        sidx_nxt = '0;
        hit_nxt  = 1'b0;
        next_nxt = item_r.from_state;
      end
      ST_REG_CHK: begin
        if (inside_hit) begin
          if (32'(rbit) < 32'(ACTION_BITS)) begin
            acc_nxt = (acc_r | (32'd1 << rbit)) & AMASK;
          end
          ridx_nxt = 6'(rcnt);
        end else begin
          ridx_nxt = ridx_r + 6'd1;
        end
        state_nxt = ST_REG_RD;
      end
      ST_LBL_RD: begin
        if ((32'(item_r.from_state) >= 32'(NUM_STATES)) || (7'(didx_r) >= scnt)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_LBL_CHK;
        end
      end
      ST_LBL_CHK: begin
        if (vld_rd && (lbl_rd == acc_r)) begin
          hit_nxt   = 1'b1;
          next_nxt  = 4'(didx_r);
          state_nxt = ST_DONE;
        end else if (last_slot) begin
          sidx_nxt  = '0;
          didx_nxt  = didx_r + 7'd1;
          state_nxt = last_dest ? ST_DONE : ST_LBL_RD;
        end else begin
          sidx_nxt  = sidx_r + 6'd1;
          state_nxt = ST_LBL_RD;
        end
      end
      ST_DONE: begin
        acc_nxt   = '0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= '0;
      ridx_r  <= '0;
      didx_r  <= '0;
      sidx_r  <= '0;
      hit_r   <= 1'b0;
      next_r  <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      ridx_r  <= ridx_nxt;
      didx_r  <= didx_nxt;
      sidx_r  <= sidx_nxt;
      hit_r   <= hit_nxt;
      next_r  <= next_nxt;
    end
  end

  // outputs
  always_comb begin
    busy      = (state_r != ST_IDLE) || clr_busy;
    out_valid = (state_r == ST_DONE);
    out_item.next_state  = next_r;
    out_item.action_word = acc_r;
    out_item.matched     = hit_r;
  end
endmodule
`default_nettype wire

/* hdl/rla_checker.sv */
// port-level checker for the region label automaton step core, bound to top
// depends on rla_pkg and the defines header
`include "region_label_automaton_step_core_defines.svh"
`default_nettype none
module rla_checker
  import rla_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire rla_out_t out_item
);
  `RLA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept must raise busy")
  `RLA_ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid, busy, "result outside a transaction")
  `RLA_ASSERT_NEXT(a_strobe_one, clk, rst_n, out_valid, !out_valid, "result strobe too long")
  `RLA_ASSERT_NEXT(a_idle_after, clk, rst_n, out_valid, !busy, "busy after result")
  `RLA_ASSERT_IMP(a_result_known, clk, rst_n, out_valid, !$isunknown(out_item), "unknown result")
endmodule
bind region_label_automaton_step_core rla_checker u_rla_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire
